[sv/mrrs_pkg.sv]
// Package for the multilevel round-robin scheduler: sizes, codes and shared types.
// Depends on nothing; used by the interfaces and every module.
package mrrs_pkg;

  localparam int NumTasksDef      = 64;
  localparam int NumLevelsDef     = 8;
  localparam int TasksPerLevelDef = 16;

  localparam int TaskW  = 6;
  localparam int LevelW = 4;
  localparam int SliceW = 8;

  localparam logic [SliceW-1:0] InitSlice = 8'd2;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_SLEEP = 2'd2,
    ACT_TIMER = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_SLEEP = 2'd1,
    ST_RUN   = 2'd2
  } task_state_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_FULL    = 2'd2,
    STS_NO_RUN  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [TaskW-1:0]  task_id;
    logic [LevelW-1:0] level;
    logic [SliceW-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [TaskW-1:0]  result_task;
    logic [SliceW-1:0] slice;
    logic              load_timer;
    logic              switched;
    logic [1:0]        status;
  } rsp_t;

endpackage

[sv/mrrs_if.sv]
// Valid/ready channel carrying one scheduler request or one response.
// Depends on mrrs_pkg.
interface mrrs_req_if;
  logic           valid;
  logic           ready;
  mrrs_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrrs_rsp_if;
  logic           valid;
  logic           ready;
  mrrs_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/mrrs_task_mem.sv]
// Per-task table (state, level, slice) in one synchronous memory with registered read.
// Depends on mrrs_pkg. Rows never written read as free, level 0, slice 0.
module mrrs_task_mem #(
  parameter int NUM_TASKS  = mrrs_pkg::NumTasksDef,
  parameter int NUM_LEVELS = mrrs_pkg::NumLevelsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(NUM_TASKS)-1:0]  rd_addr,
  output logic [1:0]                    rd_state,
  output logic [$clog2(NUM_LEVELS+1)-1:0] rd_level,
  output logic [mrrs_pkg::SliceW-1:0]   rd_slice,
  input  logic                          wr_en,
  input  logic [$clog2(NUM_TASKS)-1:0]  wr_addr,
  input  logic [1:0]                    wr_state,
  input  logic [$clog2(NUM_LEVELS+1)-1:0] wr_level,
  input  logic [mrrs_pkg::SliceW-1:0]   wr_slice
);
  localparam int LW = $clog2(NUM_LEVELS+1);
  localparam int DW = 2 + LW + mrrs_pkg::SliceW;

  logic [DW-1:0]        mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] vld_r;
  logic [DW-1:0]        rd_r;
  logic                 rd_vld_r;

  // Task 0 is written after reset by the controller's init state; valid bits cover the rest.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_state, wr_level, wr_slice};
    end
    rd_r     <= (wr_en && wr_addr == rd_addr) ? {wr_state, wr_level, wr_slice}
                                                : mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr] || (wr_en && wr_addr == rd_addr);
  end

  assign rd_state = rd_vld_r ? rd_r[DW-1 -: 2] : 2'(mrrs_pkg::ST_FREE);
  assign rd_level = rd_vld_r ? rd_r[mrrs_pkg::SliceW +: LW] : '0;
  assign rd_slice = rd_vld_r ? rd_r[mrrs_pkg::SliceW-1:0] : '0;
endmodule

[sv/mrrs_list_mem.sv]
// Run-list storage: one synchronous memory indexed by {level, slot}, with registered read.
// Depends on mrrs_pkg. Entries are only read below a level's count, so no clearing.
module mrrs_list_mem #(
  parameter int NUM_TASKS       = mrrs_pkg::NumTasksDef,
  parameter int NUM_LEVELS      = mrrs_pkg::NumLevelsDef,
  parameter int TASKS_PER_LEVEL = mrrs_pkg::TasksPerLevelDef
) (
  input  logic                                  clk,
  input  logic [$clog2(NUM_LEVELS*TASKS_PER_LEVEL)-1:0] rd_addr,
  output logic [$clog2(NUM_TASKS)-1:0]          rd_data,
  input  logic                                  wr_en,
  input  logic [$clog2(NUM_LEVELS*TASKS_PER_LEVEL)-1:0] wr_addr,
  input  logic [$clog2(NUM_TASKS)-1:0]          wr_data
);
  localparam int Depth = NUM_LEVELS * TASKS_PER_LEVEL;

  logic [$clog2(NUM_TASKS)-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

[sv/mrrs_ctrl.sv]
// Sequencer that runs each request as a series of memory read/modify/write steps.
// Depends on mrrs_pkg; drives mrrs_task_mem and mrrs_list_mem ports.
module mrrs_ctrl #(
  parameter int NUM_TASKS       = mrrs_pkg::NumTasksDef,
  parameter int NUM_LEVELS      = mrrs_pkg::NumLevelsDef,
  parameter int TASKS_PER_LEVEL = mrrs_pkg::TasksPerLevelDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  mrrs_pkg::req_t        req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output mrrs_pkg::rsp_t        rsp,
  // task memory
  output logic [$clog2(NUM_TASKS)-1:0]    t_rd_addr,
  input  logic [1:0]                      t_rd_state,
  input  logic [$clog2(NUM_LEVELS+1)-1:0] t_rd_level,
  input  logic [mrrs_pkg::SliceW-1:0]     t_rd_slice,
  output logic                            t_wr_en,
  output logic [$clog2(NUM_TASKS)-1:0]    t_wr_addr,
  output logic [1:0]                      t_wr_state,
  output logic [$clog2(NUM_LEVELS+1)-1:0] t_wr_level,
  output logic [mrrs_pkg::SliceW-1:0]     t_wr_slice,
  // list memory
  output logic [$clog2(NUM_LEVELS*TASKS_PER_LEVEL)-1:0] l_rd_addr,
  input  logic [$clog2(NUM_TASKS)-1:0]                  l_rd_data,
  output logic                                          l_wr_en,
  output logic [$clog2(NUM_LEVELS*TASKS_PER_LEVEL)-1:0] l_wr_addr,
  output logic [$clog2(NUM_TASKS)-1:0]                  l_wr_data
);
  localparam int TW  = $clog2(NUM_TASKS);
  localparam int LW  = $clog2(NUM_LEVELS+1);
  localparam int LIW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int SW  = $clog2(TASKS_PER_LEVEL);
  localparam int CW  = $clog2(TASKS_PER_LEVEL+1);
  localparam int AW  = $clog2(NUM_LEVELS*TASKS_PER_LEVEL);
  localparam int SLW = mrrs_pkg::SliceW;

  typedef enum logic [11:0] {
    S_INIT  = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_ARD   = 12'b000000000100, // alloc scan: read issued
    S_TRD   = 12'b000000001000, // task row read for run/sleep
    S_RUNW  = 12'b000000010000,
    S_FIND  = 12'b000000100000, // search run list for the sleeping task
    S_SHIFT = 12'b000001000000, // compaction: read slot i+1
    S_SHW   = 12'b000010000000,
    S_PICK  = 12'b000100000000, // choose executing task
    S_ERD   = 12'b001000000000, // list entry read for exec task
    S_SRD   = 12'b010000000000, // slice read of the reported task
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]  cnt_r  [NUM_LEVELS];
  logic [SW-1:0]  cur_r  [NUM_LEVELS];
  logic [LIW-1:0] act_r;
  logic           recheck_r;
  logic [TW-1:0]  exec_r;

  mrrs_pkg::req_t req_r;
  logic [TW:0]    scan_r;     // alloc scan index, one bit wider for the end
  logic [LIW-1:0] lv_r;       // level under work
  logic [CW-1:0]  idx_r;
  logic [TW-1:0]  prev_r;
  logic [TW-1:0]  rtask_r;
  logic [1:0]     status_r;
  logic           load_r, sw_r, is_alloc_r, rd_pend_r;
  logic [SLW-1:0] slice_r;

  // Lowest-numbered nonempty level, searched over all NUM_LEVELS levels.
  logic           any_nz;
  logic [LIW-1:0] top_lv;
  always_comb begin
    any_nz = 1'b0;
    top_lv = '0;
    for (int i = NUM_LEVELS-1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        any_nz = 1'b1;
        top_lv = LIW'(i);
      end
    end
  end

  logic [TW-1:0] tid_sized;
  logic          tid_ok;
  assign tid_sized = TW'(req_r.task_id);
  assign tid_ok    = (32'(req_r.task_id) < NUM_TASKS);

  // Run level: new level when nonnegative, else stored one; saturate to the top.
  logic [LW:0]    run_lv_raw;
  logic [LIW-1:0] run_lv;
  always_comb begin
    run_lv_raw = req_r.level[3] ? (LW+1)'(t_rd_level) : (LW+1)'(req_r.level[2:0]);
    run_lv = (32'(run_lv_raw) >= NUM_LEVELS) ? LIW'(NUM_LEVELS-1) : LIW'(run_lv_raw);
  end

  // A timer only finds a task when the level it ends up on is nonempty.
  logic pick_found;
  assign pick_found = (req_r.action == 2'(mrrs_pkg::ACT_TIMER)) ?
                      (recheck_r ? any_nz : (cnt_r[act_r] != '0)) : any_nz;

  function automatic logic [AW-1:0] ladr(input logic [LIW-1:0] l, input logic [CW-1:0] s);
    logic [31:0] a;
    a = 32'(l) * TASKS_PER_LEVEL + 32'(s);
    return AW'(a);
  endfunction

  logic [CW-1:0] pick_cur;
  assign pick_cur = (CW'(cur_r[act_r]) >= cnt_r[act_r]) ? '0 : CW'(cur_r[act_r]);

  assign req_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_OUT);
  assign rsp.result_task = rtask_r;
  assign rsp.slice       = slice_r;
  assign rsp.load_timer  = load_r;
  assign rsp.switched    = sw_r;
  assign rsp.status      = status_r;

  always_comb begin
    state_nxt  = state_r;
    t_rd_addr  = tid_sized;
    t_wr_en    = 1'b0;
    t_wr_addr  = tid_sized;
    t_wr_state = t_rd_state;
    t_wr_level = t_rd_level;
    t_wr_slice = t_rd_slice;
    l_rd_addr  = ladr(lv_r, idx_r);
    l_wr_en    = 1'b0;
    l_wr_addr  = ladr(lv_r, idx_r);
    l_wr_data  = l_rd_data;
    case (state_r)
      S_INIT: begin
        t_wr_en    = 1'b1;
        t_wr_addr  = '0;
        t_wr_state = 2'(mrrs_pkg::ST_RUN);
        t_wr_level = '0;
        t_wr_slice = mrrs_pkg::InitSlice;
        l_wr_en    = 1'b1;
        l_wr_addr  = '0;
        l_wr_data  = '0;
        state_nxt  = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          case (mrrs_pkg::action_t'(req.action))
            mrrs_pkg::ACT_ALLOC: state_nxt = S_ARD;
            mrrs_pkg::ACT_TIMER: state_nxt = S_PICK;
            default:             state_nxt = S_TRD;
          endcase
        end
      end
      S_ARD: begin
        t_rd_addr = TW'(scan_r);
        if (rd_pend_r && t_rd_state == 2'(mrrs_pkg::ST_FREE)) begin
          t_wr_en    = 1'b1;
          t_wr_addr  = TW'(scan_r - 1'b1);
          t_wr_state = 2'(mrrs_pkg::ST_SLEEP);
          state_nxt  = S_SRD;
        end else if (rd_pend_r && 32'(scan_r) >= NUM_TASKS) begin
          state_nxt = S_OUT;
        end
      end
      S_TRD: begin
        if (rd_pend_r) begin
          if (!tid_ok) begin
            state_nxt = S_SRD;
          end else if (req_r.action == 2'(mrrs_pkg::ACT_RUN)) begin
            state_nxt = S_RUNW;
          end else if (t_rd_state == 2'(mrrs_pkg::ST_RUN)) begin
            t_wr_en    = 1'b1;
            t_wr_state = 2'(mrrs_pkg::ST_SLEEP);
            state_nxt  = (32'(t_rd_level) < NUM_LEVELS) ? S_FIND : S_PICK;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_RUNW: begin
        if (t_rd_state != 2'(mrrs_pkg::ST_RUN)) begin
          if (cnt_r[run_lv] < CW'(TASKS_PER_LEVEL)) begin
            t_wr_en    = 1'b1;
            t_wr_state = 2'(mrrs_pkg::ST_RUN);
            t_wr_level = LW'(run_lv);
            if (req_r.priority_req != '0) t_wr_slice = req_r.priority_req;
            l_wr_en   = 1'b1;
            l_wr_addr = ladr(run_lv, cnt_r[run_lv]);
            l_wr_data = tid_sized;
          end
        end else if (req_r.priority_req != '0) begin
          t_wr_en    = 1'b1;
          t_wr_slice = req_r.priority_req;
        end
        state_nxt = S_SRD;
      end
      S_FIND: begin
        if (rd_pend_r && l_rd_data == tid_sized && idx_r != '0) begin
          state_nxt = S_SHIFT;
        end else if (idx_r >= cnt_r[lv_r]) begin
          state_nxt = S_PICK;
        end
      end
      S_SHIFT: begin
        l_rd_addr = ladr(lv_r, idx_r + 1'b1);
        if (idx_r >= cnt_r[lv_r]) state_nxt = S_PICK;
        else state_nxt = S_SHW;
      end
      S_SHW: begin
        l_wr_en   = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_PICK: begin
        if (req_r.action == 2'(mrrs_pkg::ACT_SLEEP) && tid_sized != exec_r) begin
          state_nxt = S_SRD;
        end else if (pick_found) begin
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_ERD: begin
        l_rd_addr = ladr(act_r, pick_cur);
        if (rd_pend_r) state_nxt = S_SRD;
      end
      S_SRD: begin
        t_rd_addr = rtask_r;
        if (rd_pend_r) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (rsp_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_r[i] <= (i == 0) ? CW'(1) : '0;
        cur_r[i] <= '0;
      end
      act_r     <= '0;
      recheck_r <= 1'b0;
      exec_r    <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            req_r      <= req;
            scan_r     <= '0;
            rd_pend_r  <= 1'b0;
            prev_r     <= exec_r;
            rtask_r    <= exec_r;
            status_r   <= 2'(mrrs_pkg::STS_OK);
            load_r     <= 1'b0;
            sw_r       <= 1'b0;
            is_alloc_r <= (req.action == 2'(mrrs_pkg::ACT_ALLOC));
          end
        end
        S_ARD: begin
          rd_pend_r <= (state_nxt == S_ARD);
          scan_r    <= scan_r + 1'b1;
          if (rd_pend_r && t_rd_state == 2'(mrrs_pkg::ST_FREE)) begin
            rtask_r <= TW'(scan_r - 1'b1);
          end else if (rd_pend_r && 32'(scan_r) >= NUM_TASKS) begin
            rtask_r  <= '0;
            slice_r  <= '0;
            status_r <= 2'(mrrs_pkg::STS_NO_FREE);
          end
        end
        S_TRD: begin
          rd_pend_r <= ~rd_pend_r;
          if (rd_pend_r) begin
            lv_r  <= LIW'(t_rd_level);
            idx_r <= '0;
          end
        end
        S_RUNW: begin
          rd_pend_r <= 1'b0;
          if (t_rd_state != 2'(mrrs_pkg::ST_RUN)) begin
            if (cnt_r[run_lv] < CW'(TASKS_PER_LEVEL)) begin
              cnt_r[run_lv] <= cnt_r[run_lv] + 1'b1;
              recheck_r     <= 1'b1;
            end else begin
              status_r <= 2'(mrrs_pkg::STS_FULL);
            end
          end else begin
            recheck_r <= 1'b1;
          end
        end
        S_FIND: begin
          // Reads run one slot ahead of the compare.
          if (rd_pend_r && l_rd_data == tid_sized && idx_r != '0) begin
            idx_r <= idx_r - 1'b1;
            cnt_r[lv_r] <= cnt_r[lv_r] - 1'b1;
            if (CW'(cur_r[lv_r]) > idx_r - 1'b1 ||
                CW'(cur_r[lv_r]) >= cnt_r[lv_r] - 1'b1) begin
              if (CW'(cur_r[lv_r]) > idx_r - 1'b1 &&
                  CW'(cur_r[lv_r]) - 1'b1 < cnt_r[lv_r] - 1'b1)
                cur_r[lv_r] <= cur_r[lv_r] - 1'b1;
              else
                cur_r[lv_r] <= '0;
            end
            rd_pend_r <= 1'b0;
          end else begin
            idx_r     <= idx_r + 1'b1;
            rd_pend_r <= (idx_r < cnt_r[lv_r]);
          end
        end
        S_SHIFT: ;
        S_SHW: idx_r <= idx_r + 1'b1;
        S_PICK: begin
          rd_pend_r <= 1'b0;
          if (req_r.action == 2'(mrrs_pkg::ACT_TIMER)) begin
            load_r <= 1'b1;
            if (cnt_r[act_r] != '0) begin
              if (CW'(cur_r[act_r]) + 1'b1 >= cnt_r[act_r]) cur_r[act_r] <= '0;
              else cur_r[act_r] <= cur_r[act_r] + 1'b1;
            end
            if (recheck_r) begin
              if (any_nz) act_r <= top_lv;
              recheck_r <= 1'b0;
            end
            if (!pick_found)
              status_r <= 2'(mrrs_pkg::STS_NO_RUN);
          end else if (tid_sized == exec_r) begin
            if (any_nz) act_r <= top_lv;
            recheck_r <= 1'b0;
            if (!any_nz) status_r <= 2'(mrrs_pkg::STS_NO_RUN);
          end
        end
        S_ERD: begin
          rd_pend_r <= ~rd_pend_r;
          if (rd_pend_r) begin
            exec_r    <= l_rd_data;
            rtask_r   <= l_rd_data;
            sw_r      <= (l_rd_data != prev_r);
          end
        end
        S_SRD: begin
          rd_pend_r <= ~rd_pend_r;
          if (rd_pend_r) begin
            if (!(is_alloc_r && status_r == 2'(mrrs_pkg::STS_NO_FREE)))
              slice_r <= t_rd_slice;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[sv/multilevel_round_robin_scheduler.sv]
// Top level of the multilevel round-robin scheduler: channels, task and list memories.
// Depends on mrrs_pkg, mrrs_if, mrrs_task_mem, mrrs_list_mem and mrrs_ctrl.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_ready  | action, task_id, level, priority_req
//  out_    | out | out_valid/out_ready| result_task, slice, load_timer, switched, status
//
// One request at a time. Alloc scans the task memory one row a cycle; sleep walks the
// run list and compacts it, reading each later slot (S_SHIFT) and writing it back
// one place down (S_SHW). After reset, the init state writes task 0 before the first
// request is taken. The response waits in its register until taken; no new request
// until then.
module multilevel_round_robin_scheduler #(
  parameter int NUM_TASKS       = mrrs_pkg::NumTasksDef,
  parameter int NUM_LEVELS      = mrrs_pkg::NumLevelsDef,
  parameter int TASKS_PER_LEVEL = mrrs_pkg::TasksPerLevelDef
) (
  input logic         clk,
  input logic         rst_n,
  mrrs_req_if.sink    in_ch,
  mrrs_rsp_if.source  out_ch
);
  localparam int TW = $clog2(NUM_TASKS);
  localparam int LW = $clog2(NUM_LEVELS+1);
  localparam int AW = $clog2(NUM_LEVELS*TASKS_PER_LEVEL);

  logic [TW-1:0] t_rd_addr, t_wr_addr;
  logic [1:0]    t_rd_state, t_wr_state;
  logic [LW-1:0] t_rd_level, t_wr_level;
  logic [7:0]    t_rd_slice, t_wr_slice;
  logic          t_wr_en;
  logic [AW-1:0] l_rd_addr, l_wr_addr;
  logic [TW-1:0] l_rd_data, l_wr_data;
  logic          l_wr_en;
  mrrs_pkg::rsp_t rsp;

  mrrs_task_mem #(.NUM_TASKS(NUM_TASKS), .NUM_LEVELS(NUM_LEVELS)) u_task (
    .clk, .rst_n, .rd_addr(t_rd_addr), .rd_state(t_rd_state), .rd_level(t_rd_level),
    .rd_slice(t_rd_slice), .wr_en(t_wr_en), .wr_addr(t_wr_addr), .wr_state(t_wr_state),
    .wr_level(t_wr_level), .wr_slice(t_wr_slice)
  );

  mrrs_list_mem #(.NUM_TASKS(NUM_TASKS), .NUM_LEVELS(NUM_LEVELS),
                  .TASKS_PER_LEVEL(TASKS_PER_LEVEL)) u_list (
    .clk, .rd_addr(l_rd_addr), .rd_data(l_rd_data), .wr_en(l_wr_en),
    .wr_addr(l_wr_addr), .wr_data(l_wr_data)
  );

  mrrs_ctrl #(.NUM_TASKS(NUM_TASKS), .NUM_LEVELS(NUM_LEVELS),
              .TASKS_PER_LEVEL(TASKS_PER_LEVEL)) u_ctrl (
    .clk, .rst_n,
    .req_valid(in_ch.valid), .req_ready(in_ch.ready), .req(in_ch.data),
    .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready), .rsp(rsp),
    .t_rd_addr, .t_rd_state, .t_rd_level, .t_rd_slice, .t_wr_en, .t_wr_addr,
    .t_wr_state, .t_wr_level, .t_wr_slice,
    .l_rd_addr, .l_rd_data, .l_wr_en, .l_wr_addr, .l_wr_data
  );

  assign out_ch.data = rsp;

`ifndef ASSERT_OFF
  // A request is never taken while a response is still offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("request taken while response pending");
  // A timer reload never comes with a no-free or full status.
  a_load_only_on_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.load_timer |-> out_ch.data.status != 2'(mrrs_pkg::STS_NO_FREE)
    && out_ch.data.status != 2'(mrrs_pkg::STS_FULL)) else $error("bad load_timer");
  // A switch never comes with a failure status.
  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.switched |-> out_ch.data.status == 2'(mrrs_pkg::STS_OK))
    else $error("switch with failure status");
`endif
endmodule
